FILE: hdl/rms_pkg.sv
package rms_pkg;

    // Field widths and run capacity.
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_BITS   = 8;
    localparam int MAX_SAMPLES = 1048576;
    localparam int CNT_W       = 21;
    localparam int SUM_W       = 37;
    localparam int SQ_W        = 53;
    localparam int OUT_W       = 24;

    // Datapath widths, mostly derived from the accumulator widths.
    localparam int PROD_W  = CNT_W + SQ_W;
    localparam int DEN_W   = 2 * CNT_W;
    localparam int REM_W   = DEN_W + 1;
    localparam int QUO_W   = 48;
    localparam int MULT_W  = SUM_W;

    // Iteration counts of the shared unit.
    localparam int MEAN_STEPS = SUM_W + FRAC_BITS;
    localparam int VAR_STEPS  = PROD_W + 2 * FRAC_BITS;
    localparam int SQRT_STEPS = QUO_W / 2;
    localparam int STEP_W     = $clog2(VAR_STEPS);

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_of_run;
    } sample_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] mean_q8;
        logic [OUT_W-1:0] stddev_q8;
        logic [CNT_W-1:0] sample_count;
        logic             stddev_valid;
        logic             count_overflow;
    } result_item_t;

endpackage

FILE: hdl/rms_alu.sv
module rms_alu import rms_pkg::*;
(
    input  alu_op_t           op,
    input  logic [PROD_W-1:0] a,
    input  logic [PROD_W-1:0] b,
    output logic [PROD_W-1:0] res,
    output logic              borrow
);

    logic [PROD_W:0] wide;

    // One wide adder serves accumulation, shift-add products, divide and root steps.
    always_comb
    begin
        case (op)
            ALU_ADD: wide = {1'b0, a} + {1'b0, b};
            ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            default: wide = {1'b0, a} + {1'b0, b};
        endcase
        res    = wide[PROD_W-1:0];
        borrow = wide[PROD_W];
    end

endmodule

FILE: hdl/rms_core.sv
module rms_core import rms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_item_t sample_item,
    output logic         res_valid,
    input  logic         res_take,
    output result_item_t res_item
);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_SQUARE  = 12'b0000_0000_0010,
        ST_ACCUM   = 12'b0000_0000_0100,
        ST_LOAD    = 12'b0000_0000_1000,
        ST_MEAN    = 12'b0000_0001_0000,
        ST_MUL_NS  = 12'b0000_0010_0000,
        ST_MUL_SS  = 12'b0000_0100_0000,
        ST_SUB     = 12'b0000_1000_0000,
        ST_MUL_DEN = 12'b0001_0000_0000,
        ST_VAR     = 12'b0010_0000_0000,
        ST_SQRT    = 12'b0100_0000_0000,
        ST_DONE    = 12'b1000_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SQ_W-1:0]        sumsq_reg, sumsq_next;
    logic                   ovf_reg, ovf_next;

    logic [SAMPLE_W-1:0]    x_reg, x_next;
    logic                   last_reg, last_next;
    logic [2*SAMPLE_W-1:0]  sq_reg, sq_next;
    logic [PROD_W-1:0]      shift_reg, shift_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [MULT_W-1:0]      mult_reg, mult_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic                   sat_reg, sat_next;
    logic [OUT_W-1:0]       mean_reg, mean_next;
    logic [OUT_W-1:0]       sd_reg, sd_next;

    alu_op_t                alu_op;
    logic [PROD_W-1:0]      alu_a, alu_b, alu_res;
    logic                   alu_borrow;

    logic [REM_W-1:0]       div_shifted, div_den, root_shifted, root_trial;
    logic [QUO_W-1:0]       div_quo;
    logic                   div_sat, quo_bit;
    logic [CNT_W-1:0]       cnt_dec;
    logic                   run_multi;

    rms_alu u_alu
    (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    // Operands of the restoring divide and square root steps.
    assign div_shifted  = {rem_reg[REM_W-2:0], shift_reg[PROD_W-1]};
    assign root_shifted = {rem_reg[REM_W-3:0], shift_reg[PROD_W-1 -: 2]};
    assign root_trial   = {quo_reg[REM_W-3:0], 2'b01};
    assign quo_bit      = ~alu_borrow;
    assign div_quo      = {quo_reg[QUO_W-2:0], quo_bit};
    assign div_sat      = sat_reg | quo_reg[QUO_W-1];
    assign cnt_dec      = count_reg - CNT_W'(1);
    assign run_multi    = (count_reg >= CNT_W'(2));

    // The divisor is the count for the mean and n*(n-1) for the variance.
    always_comb
    begin
        if (state_reg == ST_VAR)
            div_den = prod_reg[REM_W-1:0];
        else
            div_den = REM_W'(count_reg);
    end

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        ovf_next   = ovf_reg;
        x_next     = x_reg;
        last_next  = last_reg;
        sq_next    = sq_reg;
        shift_next = shift_reg;
        prod_next  = prod_reg;
        mult_next  = mult_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        sat_next   = sat_reg;
        mean_next  = mean_reg;
        sd_next    = sd_reg;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        res_valid  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    x_next     = sample_item.sample;
                    last_next  = sample_item.last_of_run;
                    state_next = ST_SQUARE;
                end
            end

            ST_SQUARE:
            begin
                sq_next    = (2*SAMPLE_W)'(x_reg) * (2*SAMPLE_W)'(x_reg);
                state_next = ST_ACCUM;
            end

            // Samples past capacity are dropped and flagged.
            ST_ACCUM:
            begin
                alu_op = ALU_ADD;
                alu_a  = PROD_W'(sumsq_reg);
                alu_b  = PROD_W'(sq_reg);
                if (count_reg < CNT_W'(MAX_SAMPLES))
                begin
                    count_next = count_reg + CNT_W'(1);
                    sum_next   = sum_reg + SUM_W'(x_reg);
                    sumsq_next = alu_res[SQ_W-1:0];
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                state_next = last_reg ? ST_LOAD : ST_IDLE;
            end

            ST_LOAD:
            begin
                shift_next = {sum_reg, {(PROD_W-SUM_W){1'b0}}};
                rem_next   = '0;
                quo_next   = '0;
                sat_next   = 1'b0;
                step_next  = '0;
                state_next = ST_MEAN;
            end

            // Mean: one quotient bit of sum*2^FRAC_BITS/n per cycle.
            ST_MEAN:
            begin
                alu_op     = ALU_SUB;
                alu_a      = PROD_W'(div_shifted);
                alu_b      = PROD_W'(div_den);
                rem_next   = quo_bit ? alu_res[REM_W-1:0] : div_shifted;
                quo_next   = div_quo;
                sat_next   = div_sat;
                shift_next = shift_reg << 1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MEAN_STEPS - 1))
                begin
                    if (div_sat || (div_quo[QUO_W-1:OUT_W] != '0))
                        mean_next = '1;
                    else
                        mean_next = div_quo[OUT_W-1:0];
                    step_next = '0;
                    if (run_multi)
                    begin
                        shift_next = '0;
                        mult_next  = {count_reg, {(MULT_W-CNT_W){1'b0}}};
                        state_next = ST_MUL_NS;
                    end
                    else
                    begin
                        sd_next    = '0;
                        state_next = ST_DONE;
                    end
                end
            end

            // n * sum of squares, shift-add from the top bit of n.
            ST_MUL_NS:
            begin
                alu_op     = ALU_ADD;
                alu_a      = shift_reg << 1;
                alu_b      = mult_reg[MULT_W-1] ? PROD_W'(sumsq_reg) : '0;
                shift_next = alu_res;
                mult_next  = mult_reg << 1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CNT_W - 1))
                begin
                    mult_next  = sum_reg;
                    prod_next  = '0;
                    step_next  = '0;
                    state_next = ST_MUL_SS;
                end
            end

            // Square of the sum.
            ST_MUL_SS:
            begin
                alu_op     = ALU_ADD;
                alu_a      = prod_reg << 1;
                alu_b      = mult_reg[MULT_W-1] ? PROD_W'(sum_reg) : '0;
                prod_next  = alu_res;
                mult_next  = mult_reg << 1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    step_next  = '0;
                    state_next = ST_SUB;
                end
            end

            // Numerator of the variance, clamped at zero.
            ST_SUB:
            begin
                alu_op     = ALU_SUB;
                alu_a      = shift_reg;
                alu_b      = prod_reg;
                shift_next = alu_borrow ? '0 : alu_res;
                prod_next  = '0;
                mult_next  = {count_reg, {(MULT_W-CNT_W){1'b0}}};
                step_next  = '0;
                state_next = ST_MUL_DEN;
            end

            // Divisor n*(n-1).
            ST_MUL_DEN:
            begin
                alu_op     = ALU_ADD;
                alu_a      = prod_reg << 1;
                alu_b      = mult_reg[MULT_W-1] ? PROD_W'(cnt_dec) : '0;
                prod_next  = alu_res;
                mult_next  = mult_reg << 1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CNT_W - 1))
                begin
                    rem_next   = '0;
                    quo_next   = '0;
                    sat_next   = 1'b0;
                    step_next  = '0;
                    state_next = ST_VAR;
                end
            end

            // Scaled variance, saturated at the quotient width.
            ST_VAR:
            begin
                alu_op     = ALU_SUB;
                alu_a      = PROD_W'(div_shifted);
                alu_b      = PROD_W'(div_den);
                rem_next   = quo_bit ? alu_res[REM_W-1:0] : div_shifted;
                quo_next   = div_quo;
                sat_next   = div_sat;
                shift_next = shift_reg << 1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(VAR_STEPS - 1))
                begin
                    shift_next = {(div_sat ? {QUO_W{1'b1}} : div_quo),
                                  {(PROD_W-QUO_W){1'b0}}};
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end

            // Integer square root, two radicand bits per cycle.
            ST_SQRT:
            begin
                alu_op     = ALU_SUB;
                alu_a      = PROD_W'(root_shifted);
                alu_b      = PROD_W'(root_trial);
                rem_next   = quo_bit ? alu_res[REM_W-1:0] : root_shifted;
                quo_next   = div_quo;
                shift_next = shift_reg << 2;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    sd_next    = div_quo[OUT_W-1:0];
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end

            // Hand the result over and clear the run.
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    count_next = '0;
                    sum_next   = '0;
                    sumsq_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and run state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Working registers of the shared unit.
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        last_reg  <= last_next;
        sq_reg    <= sq_next;
        shift_reg <= shift_next;
        prod_reg  <= prod_next;
        mult_reg  <= mult_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        sat_reg   <= sat_next;
        mean_reg  <= mean_next;
        sd_reg    <= sd_next;
    end

    assign sample_stall = (state_reg != ST_IDLE);

    assign res_item.mean_q8        = mean_reg;
    assign res_item.stddev_q8      = sd_reg;
    assign res_item.sample_count   = count_reg;
    assign res_item.stddev_valid   = run_multi;
    assign res_item.count_overflow = ovf_reg;

endmodule

FILE: hdl/running_mean_stddev.sv
// Channel   Direction  Handshake                      Payload
// sample    in         sample_valid / sample_stall    sample_item_t
// result    out        result_valid / result_stall    result_item_t
//
// A sample that does not end a run is squared and accumulated; the block is busy meanwhile.
// A sample that ends a run is then carried by the single shared adder through the mean
// divide, products, variance divide and square root; a run of one sample skips all
// but the mean divide.
// Reset clears the running count, sums and overflow flag and empties the output.
// The result sits in an output register, so a new run starts while it waits.
module running_mean_stddev import rms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_item_t sample_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    logic         res_valid;
    logic         res_take;
    result_item_t res_item;
    logic         result_valid_reg, result_valid_next;
    result_item_t result_item_reg, result_item_next;

    rms_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res_item     (res_item)
    );

    // The output register takes a new item when empty or being drained.
    assign res_take = ~result_valid_reg | ~result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_item_next  = result_item_reg;
        if (res_valid && res_take)
        begin
            result_valid_next = 1'b1;
            result_item_next  = res_item;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        result_item_reg <= result_item_next;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule

FILE: hdl/rms_checker.sv
module rms_checker import rms_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         sample_valid,
    input logic         sample_stall,
    input logic         result_valid,
    input logic         result_stall,
    input result_item_t result_item
);

    // A stalled result item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("stalled result item changed");

    // Every accepted sample makes the block busy in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("sample accepted without busy cycle");

    // Standard deviation is flagged exactly for runs of two or more samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_item.sample_count != '0) &&
                         (result_item.stddev_valid == (result_item.sample_count >= CNT_W'(2))) &&
                         (result_item.stddev_valid || (result_item.stddev_q8 == '0)))
        else $error("stddev flag inconsistent with count");

    // The mean never exceeds the largest representable sample value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_item.mean_q8 <= 24'hFFFF00)
        else $error("mean out of sample range");

endmodule

bind running_mean_stddev rms_checker u_rms_checker (.*);
